// ----- src/assert_macros.svh -----
// Shared assertion macros; compiled out when ASSERT_OFF is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property holds in the same cycle as its antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Property holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- src/stl_pkg.sv -----
package stl_pkg;

    typedef enum logic [3:0] {
        K_WORD    = 4'd0,
        K_AND     = 4'd1,
        K_SEQ     = 4'd2,
        K_OR      = 4'd3,
        K_PIPE    = 4'd4,
        K_LPAREN  = 4'd5,
        K_RPAREN  = 4'd6,
        K_LESS    = 4'd7,
        K_GREATER = 4'd8,
        K_NEWLINE = 4'd9,
        K_BADCHAR = 4'd10,
        K_BADOP   = 4'd11,
        K_END     = 4'd12
    } t_kind;

    typedef enum logic [2:0] {
        H_NONE = 3'd0,
        H_AMP  = 3'd1,
        H_SEMI = 3'd2,
        H_BAR  = 3'd3,
        H_LPAR = 3'd4,
        H_LT   = 3'd5,
        H_GT   = 3'd6
    } t_held;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_CARET = 8'h5E;

    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] text_byte;
        logic       word_start;
        logic       run_end;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    [MAX_RES-1:0] slot;
    } t_bundle;

    typedef struct packed {
        t_kind kind;
        logic  used;
    } t_check;

    function automatic logic is_blank(logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == CH_NL || b == 8'h0B ||
               b == 8'h0C || b == 8'h0D;
    endfunction

    function automatic logic is_word(logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A) ||
               b == CH_BANG || b == 8'h25 || b == 8'h2B || b == 8'h2C ||
               b == 8'h2D || b == 8'h2E || b == 8'h2F || b == 8'h3A ||
               b == CH_AT || b == CH_CARET || b == 8'h5F;
    endfunction

    function automatic logic is_op(logic [7:0] b);
        return b == CH_SEMI || b == CH_BAR || b == CH_AMP || b == CH_LPAR ||
               b == CH_RPAR || b == CH_LT || b == CH_GT;
    endfunction

    function automatic t_held op_code(logic [7:0] b);
        t_held h;
        case (b)
            CH_AMP:  h = H_AMP;
            CH_SEMI: h = H_SEMI;
            CH_BAR:  h = H_BAR;
            CH_LPAR: h = H_LPAR;
            CH_LT:   h = H_LT;
            default: h = H_GT;
        endcase
        return h;
    endfunction

    // Check a held operator against the byte after it.
    function automatic t_check resolve(t_held h, logic [7:0] b);
        t_check c;
        logic   hard;
        hard   = b == CH_AMP || b == CH_SEMI || b == CH_BAR || b == CH_LT || b == CH_GT;
        c.used = 1'b0;
        c.kind = K_BADOP;
        unique case (h)
            H_AMP: begin
                if (b == CH_AMP) begin
                    c.used = 1'b1;
                    c.kind = K_AND;
                end
            end
            H_SEMI: c.kind = hard ? K_BADOP : K_SEQ;
            H_BAR: begin
                if (b == CH_BAR) begin
                    c.used = 1'b1;
                    c.kind = K_OR;
                end else begin
                    c.kind = (hard || b == CH_RPAR) ? K_BADOP : K_PIPE;
                end
            end
            H_LPAR: c.kind = hard ? K_BADOP : K_LPAREN;
            H_LT:   c.kind = (hard || b == CH_RPAR) ? K_BADOP : K_LESS;
            H_GT:   c.kind = (hard || b == CH_RPAR) ? K_BADOP : K_GREATER;
            default: c.kind = K_BADOP;
        endcase
        return c;
    endfunction

    // Append one result; drop it once all slots are taken.
    function automatic t_bundle push(t_bundle bd, t_kind k, logic [7:0] t, logic s);
        t_bundle r;
        r = bd;
        if (bd.cnt != 2'(MAX_RES)) begin
            r.slot[bd.cnt].kind       = k;
            r.slot[bd.cnt].text_byte  = t;
            r.slot[bd.cnt].word_start = s;
            r.slot[bd.cnt].run_end    = 1'b0;
            r.cnt                     = bd.cnt + 2'd1;
        end
        return r;
    endfunction

endpackage

// ----- src/stl_scan.sv -----
`include "assert_macros.svh"

module stl_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output stl_pkg::t_bundle o_bundle
);
    import stl_pkg::*;

    logic  r_token_seen, n_token_seen;
    t_held r_held, n_held;
    logic  r_in_comment, n_in_comment;
    logic  r_in_word, n_in_word;
    logic  r_disc, n_disc;

    t_bundle bd;
    t_check  chk;
    t_check  chk_end;
    logic    err;
    logic    used;
    logic    allowed;

    always_comb begin
        n_token_seen = r_token_seen;
        n_held       = r_held;
        n_in_comment = r_in_comment;
        n_in_word    = r_in_word;
        n_disc       = r_disc;
        bd           = '0;
        err          = 1'b0;
        used         = 1'b0;
        chk          = resolve(r_held, i_byte);
        allowed      = is_word(i_byte) || is_op(i_byte) || i_byte == CH_HASH ||
                       is_blank(i_byte);

        if (i_accept && !r_disc) begin
            if (r_held != H_NONE) begin
                n_held = H_NONE;
                bd     = push(bd, chk.kind, 8'h00, 1'b0);
                used   = chk.used;
                if (chk.kind == K_BADOP) begin
                    err = 1'b1;
                end else begin
                    n_token_seen = 1'b1;
                end
            end

            if (!err && !used) begin
                if (!allowed) begin
                    bd  = push(bd, K_BADCHAR, 8'h00, 1'b0);
                    err = 1'b1;
                end else if (r_in_comment) begin
                    if (i_byte == CH_NL) begin
                        n_in_comment = 1'b0;
                        if (n_token_seen && !i_last) begin
                            bd = push(bd, K_NEWLINE, 8'h00, 1'b0);
                        end
                    end
                end else if (i_byte == CH_NL) begin
                    n_in_word = 1'b0;
                    if (n_token_seen && !i_last) begin
                        bd = push(bd, K_NEWLINE, 8'h00, 1'b0);
                    end
                end else if (is_blank(i_byte)) begin
                    n_in_word = 1'b0;
                end else if (i_byte == CH_HASH) begin
                    n_in_comment = 1'b1;
                    n_in_word    = 1'b0;
                end else if (is_word(i_byte)) begin
                    bd           = push(bd, K_WORD, i_byte, !r_in_word);
                    n_in_word    = 1'b1;
                    n_token_seen = 1'b1;
                end else if (i_byte == CH_RPAR) begin
                    bd           = push(bd, K_RPAREN, 8'h00, 1'b0);
                    n_in_word    = 1'b0;
                    n_token_seen = 1'b1;
                end else begin
                    n_held    = op_code(i_byte);
                    n_in_word = 1'b0;
                end
            end
        end

        // Flush a held operator at end of stream as if no operator follows.
        chk_end = resolve(n_held, 8'h00);
        if (i_accept && !r_disc && !err && i_last) begin
            if (n_held != H_NONE) begin
                bd = push(bd, chk_end.kind, 8'h00, 1'b0);
                if (chk_end.kind == K_BADOP) begin
                    err = 1'b1;
                end
            end
            if (!err) begin
                bd = push(bd, K_END, 8'h00, 1'b0);
            end
        end

        if (bd.cnt != 2'd0) begin
            bd.slot[bd.cnt - 2'd1].run_end = 1'b1;
        end

        if (err) begin
            n_disc = 1'b1;
        end
        if (i_accept && i_last) begin
            n_token_seen = 1'b0;
            n_held       = H_NONE;
            n_in_comment = 1'b0;
            n_in_word    = 1'b0;
            n_disc       = 1'b0;
        end
    end

    assign o_bundle = bd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_seen <= 1'b0;
            r_held       <= H_NONE;
            r_in_comment <= 1'b0;
            r_in_word    <= 1'b0;
            r_disc       <= 1'b0;
        end else begin
            r_token_seen <= n_token_seen;
            r_held       <= n_held;
            r_in_comment <= n_in_comment;
            r_in_word    <= n_in_word;
            r_disc       <= n_disc;
        end
    end

    `ASSERT_SAME(a_disc_no_held, r_disc, r_held == H_NONE)
    `ASSERT_SAME(a_comment_no_held, r_in_comment, r_held == H_NONE && !r_in_word)
    `ASSERT_NEXT(a_last_clears, i_accept && i_last, !r_disc && r_held == H_NONE && !r_token_seen)
    `ASSERT_SAME(a_disc_silent, i_accept && r_disc, o_bundle.cnt == 2'd0)

endmodule

// ----- src/stl_outbuf.sv -----
`include "assert_macros.svh"

module stl_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  stl_pkg::t_bundle i_bundle,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output stl_pkg::t_result o_result
);
    import stl_pkg::*;

    t_result    [MAX_RES-1:0] r_slot;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic       at_tail;
    logic       pop;

    assign o_valid  = r_cnt != 2'd0;
    assign o_result = r_slot[r_idx];
    assign at_tail  = r_idx == r_cnt - 2'd1;
    assign pop      = o_valid && i_ready;
    // Take a new beat while the last result of the previous one leaves.
    assign o_free   = !o_valid || (pop && at_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_bundle.cnt;
            r_idx <= 2'd0;
        end else if (pop) begin
            if (at_tail) begin
                r_cnt <= 2'd0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_bundle.slot;
        end
    end

    `ASSERT_SAME(a_idx_in_range, o_valid, r_idx < r_cnt)
    `ASSERT_SAME(a_load_when_free, i_load, o_free)
    `ASSERT_NEXT(a_stall_holds, o_valid && !i_ready && !i_load, $stable(r_idx) && $stable(r_cnt))

endmodule

// ----- src/shell_token_lexer.sv -----
// Latency: results of a byte appear on the output the cycle after it is accepted.
// Throughput: one byte per cycle while each byte yields at most one result and the
//   output is ready; a byte yielding n results (up to three) holds off the next byte
//   until its last result leaves the result buffer.
// Reset: synchronous active-low i_rst_n clears lexer state and empties the buffer.
module shell_token_lexer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
    input  logic       s_axis_tlast,   // stream_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] text_byte, [8] word_start, [15:9] zero
    output logic [3:0] m_axis_tuser,   // kind
    output logic       m_axis_tlast    // run_end
);
    import stl_pkg::*;

    t_bundle bundle;
    t_result res;
    logic    free;
    logic    accept;

    assign s_axis_tready = free;
    assign accept        = s_axis_tvalid && free;

    stl_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_bundle (bundle)
    );

    stl_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_bundle (bundle),
        .o_free   (free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (res)
    );

    assign m_axis_tdata = {7'd0, res.word_start, res.text_byte};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.run_end;

endmodule

// ----- sim/shell_token_lexer_tb.sv -----
module shell_token_lexer_tb;
    import stl_pkg::*;

    localparam int RANDOM_BYTES = 200;

    typedef enum logic [2:0] {
        BC_WORD,
        BC_SPACE,
        BC_NL,
        BC_HASH,
        BC_OPER,
        BC_CLOSE,
        BC_BAD
    } t_bclass;

    // One script byte, with an optional hand-written single result.
    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;
        t_kind      k;
        logic [7:0] txt;
        logic       st;
    } t_feed;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] byte_in
    logic        s_axis_tlast = 1'b0;    // stream_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] text_byte, [8] word_start, [15:9] zero
    logic [3:0]  m_axis_tuser;           // kind
    logic        m_axis_tlast;           // run_end

    always #5 i_clk = ~i_clk;

    shell_token_lexer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // columns: byte, stream end, typed, kind, text, word start
    t_feed opening_rows [28] = '{
        {CH_NL,    1'b0, 1'b0, K_WORD,    8'h00,    1'b0},
        {8'h61,    1'b0, 1'b1, K_WORD,    8'h61,    1'b1},
        {8'h62,    1'b0, 1'b1, K_WORD,    8'h62,    1'b0},
        {8'h09,    1'b0, 1'b0, K_WORD,    8'h00,    1'b0},
        {CH_AMP,   1'b0, 1'b0, K_WORD,    8'h00,    1'b0},
        {CH_AMP,   1'b0, 1'b1, K_AND,     8'h00,    1'b0},
        {CH_BAR,   1'b0, 1'b0, K_WORD,    8'h00,    1'b0},
        {CH_BAR,   1'b0, 1'b1, K_OR,      8'h00,    1'b0},
        {CH_SEMI,  1'b0, 1'b0, K_WORD,    8'h00,    1'b0},
        {CH_LPAR,  1'b0, 1'b0, K_WORD,    8'h00,    1'b0},
        {CH_RPAR,  1'b0, 1'b0, K_WORD,    8'h00,    1'b0},
        {CH_BAR,   1'b0, 1'b0, K_WORD,    8'h00,    1'b0},
        {CH_LT,    1'b0, 1'b1, K_BADOP,   8'h00,    1'b0},
        {8'h78,    1'b1, 1'b0, K_WORD,    8'h00,    1'b0},
        {8'h7A,    1'b0, 1'b1, K_WORD,    8'h7A,    1'b1},
        {CH_GT,    1'b0, 1'b0, K_WORD,    8'h00,    1'b0},
        {8'h0D,    1'b0, 1'b0, K_WORD,    8'h00,    1'b0},
        {CH_HASH,  1'b0, 1'b0, K_WORD,    8'h00,    1'b0},
        {CH_NL,    1'b0, 1'b0, K_WORD,    8'h00,    1'b0},
        {CH_NL,    1'b1, 1'b1, K_END,     8'h00,    1'b0},
        {CH_CARET, 1'b0, 1'b1, K_WORD,    CH_CARET, 1'b1},
        {CH_SEMI,  1'b0, 1'b0, K_WORD,    8'h00,    1'b0},
        {CH_LPAR,  1'b1, 1'b0, K_WORD,    8'h00,    1'b0},
        {CH_HASH,  1'b0, 1'b0, K_WORD,    8'h00,    1'b0},
        {CH_AT,    1'b1, 1'b1, K_END,     8'h00,    1'b0},
        {8'hFF,    1'b1, 1'b1, K_BADCHAR, 8'h00,    1'b0},
        {CH_AMP,   1'b1, 1'b1, K_BADOP,   8'h00,    1'b0},
        {8'h00,    1'b1, 1'b1, K_BADCHAR, 8'h00,    1'b0}
    };

    string word_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789!%+,-./:@^_";
    string oper_set = "&|;()<>";
    string space_set = " \t\013\014\r";

    t_feed   script_q[$];
    t_result tokens_due[$];
    t_result step_res[$];
    int      picked = 0;
    int      err_cnt = 0;

    // lexer state mirror
    logic  seen_tok = 1'b0;
    logic  in_cmt = 1'b0;
    logic  word_open = 1'b0;
    logic  dropping = 1'b0;
    t_held pend_op = H_NONE;

    function automatic t_bclass classify_byte(logic [7:0] b);
        t_bclass c;
        c = BC_BAD;
        if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
            (b >= 8'h61 && b <= 8'h7A)) begin
            c = BC_WORD;
        end else begin
            case (b)
                CH_BANG, CH_AT, CH_CARET, 8'h25, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
                8'h3A, 8'h5F:                                      c = BC_WORD;
                CH_NL:                                             c = BC_NL;
                8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D:                 c = BC_SPACE;
                CH_HASH:                                           c = BC_HASH;
                CH_RPAR:                                           c = BC_CLOSE;
                CH_AMP, CH_SEMI, CH_BAR, CH_LPAR, CH_LT, CH_GT:    c = BC_OPER;
                default:                                           c = BC_BAD;
            endcase
        end
        return c;
    endfunction

    // Decide what a held operator becomes given the byte after it.
    function automatic t_kind settle_op(t_held h, logic [7:0] b, output logic eaten);
        logic  clash;
        t_kind k;
        clash = b == CH_AMP || b == CH_SEMI || b == CH_BAR || b == CH_LT || b == CH_GT;
        eaten = 1'b0;
        k = K_BADOP;
        case (h)
            H_AMP: begin
                if (b == CH_AMP) begin
                    eaten = 1'b1;
                    k = K_AND;
                end
            end
            H_SEMI: if (!clash) k = K_SEQ;
            H_BAR: begin
                if (b == CH_BAR) begin
                    eaten = 1'b1;
                    k = K_OR;
                end else if (!clash && b != CH_RPAR) begin
                    k = K_PIPE;
                end
            end
            H_LPAR: if (!clash) k = K_LPAREN;
            H_LT: if (!clash && b != CH_RPAR) k = K_LESS;
            H_GT: if (!clash && b != CH_RPAR) k = K_GREATER;
            default: k = K_BADOP;
        endcase
        return k;
    endfunction

    function automatic void add_tok(t_kind k, logic [7:0] t, logic s);
        t_result r;
        r.kind = k;
        r.text_byte = t;
        r.word_start = s;
        r.run_end = 1'b0;
        // the block has room for three results per byte; drop the rest
        if (step_res.size() < MAX_RES) step_res.push_back(r);
    endfunction

    task automatic clear_lexer();
        seen_tok = 1'b0;
        in_cmt = 1'b0;
        word_open = 1'b0;
        dropping = 1'b0;
        pend_op = H_NONE;
    endtask

    // Work out the tokens one script byte produces; leaves them in step_res.
    task automatic lex_byte(logic [7:0] b, logic fin);
        t_kind   k;
        logic    eaten;
        logic    err;
        t_bclass c;
        t_result r;
        step_res.delete();
        eaten = 1'b0;
        err = 1'b0;
        c = classify_byte(b);
        if (dropping) begin
            if (fin) clear_lexer();
        end else begin
            if (pend_op != H_NONE) begin
                k = settle_op(pend_op, b, eaten);
                pend_op = H_NONE;
                add_tok(k, 8'h00, 1'b0);
                if (k == K_BADOP) err = 1'b1;
                else seen_tok = 1'b1;
            end
            if (!err && !eaten) begin
                if (c == BC_BAD) begin
                    add_tok(K_BADCHAR, 8'h00, 1'b0);
                    err = 1'b1;
                end else if (in_cmt) begin
                    if (c == BC_NL) begin
                        in_cmt = 1'b0;
                        if (seen_tok && !fin) add_tok(K_NEWLINE, 8'h00, 1'b0);
                    end
                end else begin
                    case (c)
                        BC_NL: begin
                            word_open = 1'b0;
                            if (seen_tok && !fin) add_tok(K_NEWLINE, 8'h00, 1'b0);
                        end
                        BC_SPACE: word_open = 1'b0;
                        BC_HASH: begin
                            in_cmt = 1'b1;
                            word_open = 1'b0;
                        end
                        BC_WORD: begin
                            add_tok(K_WORD, b, !word_open);
                            word_open = 1'b1;
                            seen_tok = 1'b1;
                        end
                        BC_CLOSE: begin
                            add_tok(K_RPAREN, 8'h00, 1'b0);
                            word_open = 1'b0;
                            seen_tok = 1'b1;
                        end
                        default: begin
                            case (b)
                                CH_AMP:  pend_op = H_AMP;
                                CH_SEMI: pend_op = H_SEMI;
                                CH_BAR:  pend_op = H_BAR;
                                CH_LPAR: pend_op = H_LPAR;
                                CH_LT:   pend_op = H_LT;
                                default: pend_op = H_GT;
                            endcase
                            word_open = 1'b0;
                        end
                    endcase
                end
            end
            if (!err && fin) begin
                // at end of stream a held operator sees a harmless follower
                if (pend_op != H_NONE) begin
                    k = settle_op(pend_op, 8'h00, eaten);
                    pend_op = H_NONE;
                    add_tok(k, 8'h00, 1'b0);
                    if (k == K_BADOP) err = 1'b1;
                end
                if (!err) add_tok(K_END, 8'h00, 1'b0);
            end
            if (err) dropping = 1'b1;
            if (fin) clear_lexer();
            if (step_res.size() > 0) begin
                r = step_res.pop_back();
                r.run_end = 1'b1;
                step_res.push_back(r);
            end
        end
    endtask

    // Build one random script, mostly well formed, and queue its bytes.
    task automatic add_script();
        logic [7:0] chars_q[$];
        int         n_tok;
        int         roll;
        int         len;
        int         i;
        int         j;
        t_feed      f;
        n_tok = $urandom_range(1, 10);
        for (i = 0; i < n_tok; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 42) begin
                len = $urandom_range(1, 5);
                for (j = 0; j < len; j++)
                    chars_q.push_back(word_set[$urandom_range(0, word_set.len() - 1)]);
                if ($urandom_range(0, 9) < 7)
                    chars_q.push_back(space_set[$urandom_range(0, space_set.len() - 1)]);
            end else if (roll < 54) begin
                chars_q.push_back(space_set[$urandom_range(0, space_set.len() - 1)]);
            end else if (roll < 62) begin
                chars_q.push_back(CH_NL);
            end else if (roll < 86) begin
                case ($urandom_range(0, 7))
                    0: begin chars_q.push_back(CH_AMP); chars_q.push_back(CH_AMP); end
                    1: begin chars_q.push_back(CH_BAR); chars_q.push_back(CH_BAR); end
                    2: chars_q.push_back(CH_BAR);
                    3: chars_q.push_back(CH_SEMI);
                    4: chars_q.push_back(CH_LPAR);
                    5: chars_q.push_back(CH_RPAR);
                    6: chars_q.push_back(CH_LT);
                    default: chars_q.push_back(CH_GT);
                endcase
                // a safe follower keeps the operator check passing
                if ($urandom_range(0, 4) < 4) chars_q.push_back(8'h20);
                else chars_q.push_back(word_set[$urandom_range(0, word_set.len() - 1)]);
            end else if (roll < 93) begin
                chars_q.push_back(CH_HASH);
                len = $urandom_range(0, 4);
                for (j = 0; j < len; j++) begin
                    if ($urandom_range(0, 1) == 0)
                        chars_q.push_back(oper_set[$urandom_range(0, oper_set.len() - 1)]);
                    else
                        chars_q.push_back(word_set[$urandom_range(0, word_set.len() - 1)]);
                end
                chars_q.push_back(CH_NL);
            end else if (roll < 97) begin
                chars_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                chars_q.push_back(oper_set[$urandom_range(0, oper_set.len() - 1)]);
            end
        end
        if ($urandom_range(0, 9) < 4) begin
            chars_q.push_back(CH_NL);
        end
        picked += chars_q.size();
        for (j = 0; j < chars_q.size(); j++) begin
            f.ch = chars_q[j];
            f.fin = (j == chars_q.size() - 1);
            f.typed = 1'b0;
            f.k = K_WORD;
            f.txt = 8'h00;
            f.st = 1'b0;
            script_q.push_back(f);
        end
    endtask

    // Sender: bursts of beats separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin : feed_drv
        t_feed   cur;
        t_feed   nxt;
        t_result want;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                cur = script_q.pop_front();
                lex_byte(cur.ch, cur.fin);
                if (cur.typed) begin
                    want.kind = cur.k;
                    want.text_byte = cur.txt;
                    want.word_start = cur.st;
                    want.run_end = 1'b1;
                    tokens_due.push_back(want);
                end else begin
                    foreach (step_res[i]) tokens_due.push_back(step_res[i]);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (script_q.size() > 0) begin
                nxt = script_q[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= nxt.ch;
                s_axis_tlast <= nxt.fin;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: rotate a stall pattern, reloaded now and then.
    logic [7:0] stall_pat = 8'hFF;
    int         pat_age = 0;

    always @(posedge i_clk) begin
        pat_age++;
        if (pat_age == 48) begin
            pat_age = 0;
            case ($urandom_range(0, 3))
                0: stall_pat = 8'hFF;
                1: stall_pat = 8'h55;
                default: stall_pat = 8'($urandom);
            endcase
            if (stall_pat == 8'h00) stall_pat = 8'h01;
        end
        stall_pat = {stall_pat[0], stall_pat[7:1]};
        m_axis_tready <= stall_pat[0];
    end

    always @(posedge i_clk) begin : tok_chk
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = t_kind'(m_axis_tuser);
            got.text_byte = m_axis_tdata[7:0];
            got.word_start = m_axis_tdata[8];
            got.run_end = m_axis_tlast;
            if (tokens_due.size() == 0) begin
                $display("%0t: token with none pending: kind=%0d tdata=%h last=%b",
                         $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                err_cnt++;
            end else begin
                want = tokens_due.pop_front();
                if (got !== want || m_axis_tdata[15:9] !== 7'd0) begin
                    $display("%0t: token mismatch: expected kind=%0d text=%h start=%b last=%b, got kind=%0d tdata=%h last=%b",
                             $time, want.kind, want.text_byte, want.word_start, want.run_end,
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        int r;
        for (r = 0; r < 28; r++) script_q.push_back(opening_rows[r]);
        while (picked < RANDOM_BYTES) add_script();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (script_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("shell_token_lexer_tb: done, clean");
        end else begin
            $display("shell_token_lexer_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("shell_token_lexer_tb: done, errors");
        $finish;
    end

endmodule
